// ----- rtl/apba_pkg.sv -----
package apba_pkg;

  localparam int unsigned LEN_W = 11;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned ID_W = 8;
  localparam int unsigned WORD_W = 32;

  localparam logic [2:0] MODE_CREATE = 3'd0;
  localparam logic [2:0] MODE_STORE = 3'd1;
  localparam logic [2:0] MODE_LOAD = 3'd2;
  localparam logic [2:0] MODE_QUERY = 3'd3;
  localparam logic [2:0] MODE_FREE = 3'd4;
  localparam logic [2:0] MODE_CLEAR = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [ID_W-1:0] slot_id;
    logic [IDX_W-1:0] elem_index;
    logic [LEN_W-1:0] length;
    logic signed [WORD_W-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic ok;
    logic signed [WORD_W-1:0] read_value;
    logic [LEN_W-1:0] array_length;
    logic [IDX_W-1:0] array_base;
    logic [LEN_W-1:0] words_used;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_FILL = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic fill;
  } cmd_t;

  typedef struct packed {
    logic create_ok;
    logic fill_last;
  } sts_t;

endpackage

// ----- rtl/apba_ctrl.sv -----
module apba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  apba_pkg::sts_t sts,
  output apba_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_strobe
);
  import apba_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy = !((state_r == ST_IDLE) || (state_r == ST_RESP));
  assign accept = start && !busy;
  assign out_strobe = (state_r == ST_RESP);

  assign cmd.accept = accept;
  assign cmd.exec = (state_r == ST_EXEC);
  assign cmd.fill = (state_r == ST_FILL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = sts.create_ok ? ST_FILL : ST_RESP;
      end
      ST_FILL: begin
        if (sts.fill_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/apba_dp.sv -----
module apba_dp #(
  parameter int unsigned ARRAY_SLOTS = 16,
  parameter int unsigned POOL_WORDS = 1024,
  parameter int unsigned MAX_LENGTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  apba_pkg::cmd_t cmd,
  input  apba_pkg::in_t  in_data,
  output apba_pkg::sts_t sts,
  output apba_pkg::out_t out_data
);
  import apba_pkg::*;

  localparam int unsigned SW = (ARRAY_SLOTS > 1) ? $clog2(ARRAY_SLOTS) : 1;
  localparam int unsigned SD = 1 << SW;
  localparam int unsigned PW = $clog2(POOL_WORDS);
  localparam int unsigned BW = PW + 1;
  localparam int unsigned CW = ((BW > LEN_W) ? BW : LEN_W) + 1;

  in_t                      req_r;
  logic [PW-1:0]            off_mem [SD];
  logic [LEN_W-1:0]         len_mem [SD];
  logic [PW-1:0]            off_rd_r;
  logic [LEN_W-1:0]         len_rd_r;
  logic [SD-1:0]            act_r;
  logic [BW-1:0]            bump_r;
  logic [PW-1:0]            fill_base_r;
  logic [LEN_W-1:0]         cnt_r;
  logic [WORD_W-1:0]        pool_mem [POOL_WORDS];
  logic [WORD_W-1:0]        pool_rd_r;
  logic                     rd_sel_r;
  logic                     ok_r;
  logic [LEN_W-1:0]         qlen_r;
  logic [IDX_W-1:0]         qbase_r;

  logic                     id_ok;
  logic [SW-1:0]            sidx;
  logic                     live;
  logic                     in_bounds;
  logic [CW-1:0]            bump_sum;
  logic                     create_ok;
  logic                     ok_nxt;
  logic [PW-1:0]            elem_addr;
  logic                     pool_we;
  logic [PW-1:0]            pool_waddr;
  logic [WORD_W-1:0]        pool_wdata;
  logic                     pool_re;

  assign id_ok = {1'b0, req_r.slot_id} < (ID_W + 1)'(ARRAY_SLOTS);
  assign sidx = req_r.slot_id[SW-1:0];
  assign live = id_ok && act_r[sidx];
  assign in_bounds = live && ({1'b0, req_r.elem_index} < len_rd_r);
  assign bump_sum = CW'(bump_r) + CW'(req_r.length);
  assign create_ok = (req_r.mode == MODE_CREATE) && id_ok && !act_r[sidx] &&
                     (req_r.length != '0) &&
                     (17'(req_r.length) <= 17'(MAX_LENGTH)) &&
                     (bump_sum <= CW'(POOL_WORDS));
  assign elem_addr = PW'(CW'(off_rd_r) + CW'(req_r.elem_index));

  always_comb begin
    case (req_r.mode)
      MODE_CREATE: ok_nxt = create_ok;
      MODE_STORE:  ok_nxt = in_bounds;
      MODE_LOAD:   ok_nxt = in_bounds;
      MODE_QUERY:  ok_nxt = live;
      MODE_FREE:   ok_nxt = live;
      MODE_CLEAR:  ok_nxt = 1'b1;
      default:     ok_nxt = 1'b0;
    endcase
  end

  assign sts.create_ok = cmd.exec && create_ok;
  assign sts.fill_last = (cnt_r == (req_r.length - LEN_W'(1)));

  always_comb begin
    pool_we = 1'b0;
    pool_waddr = elem_addr;
    pool_wdata = req_r.write_value;
    if (cmd.fill) begin
      pool_we = 1'b1;
      pool_waddr = PW'(CW'(fill_base_r) + CW'(cnt_r));
      pool_wdata = '0;
    end else if (cmd.exec && (req_r.mode == MODE_STORE) && in_bounds) begin
      pool_we = 1'b1;
    end
  end

  assign pool_re = cmd.exec && (req_r.mode == MODE_LOAD) && in_bounds;

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
    if (pool_re) pool_rd_r <= pool_mem[elem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
      off_rd_r <= off_mem[in_data.slot_id[SW-1:0]];
      len_rd_r <= len_mem[in_data.slot_id[SW-1:0]];
    end
    if (cmd.exec && create_ok) begin
      off_mem[sidx] <= bump_r[PW-1:0];
      len_mem[sidx] <= req_r.length;
      fill_base_r <= bump_r[PW-1:0];
    end
    if (cmd.exec) begin
      cnt_r <= '0;
      ok_r <= ok_nxt;
      rd_sel_r <= pool_re;
      qlen_r <= ((req_r.mode == MODE_QUERY) && live) ? len_rd_r : '0;
      qbase_r <= ((req_r.mode == MODE_QUERY) && live) ? IDX_W'(off_rd_r) : '0;
    end else if (cmd.fill) begin
      cnt_r <= cnt_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      bump_r <= '0;
    end else if (cmd.exec) begin
      if (req_r.mode == MODE_CLEAR) begin
        act_r <= '0;
        bump_r <= '0;
      end else if (create_ok) begin
        act_r[sidx] <= 1'b1;
        bump_r <= BW'(bump_sum);
      end else if ((req_r.mode == MODE_FREE) && live) begin
        act_r[sidx] <= 1'b0;
      end
    end
  end

  assign out_data.ok = ok_r;
  assign out_data.read_value = rd_sel_r ? pool_rd_r : '0;
  assign out_data.array_length = qlen_r;
  assign out_data.array_base = qbase_r;
  assign out_data.words_used = LEN_W'(bump_r);

endmodule

// ----- rtl/array_pool_bump_allocator_unit.sv -----
// Each item gives one result. Outside a successful create, an accepted item passes
// through the execute state and then the response state, where the result is strobed;
// start may be accepted again in the cycle that shows the result.
// A successful create zero-fills the new array one word per cycle before its result.
// Synchronous active-low reset empties every array and the bump pointer; pool words
// are left as they were. Results cannot be stalled by the receiver.
module array_pool_bump_allocator_unit #(
  parameter int unsigned ARRAY_SLOTS = 16,
  parameter int unsigned POOL_WORDS = 1024,
  parameter int unsigned MAX_LENGTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  apba_pkg::in_t  in_data,
  output logic           out_strobe,
  output apba_pkg::out_t out_data
);
  import apba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  apba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  apba_dp #(
    .ARRAY_SLOTS (ARRAY_SLOTS),
    .POOL_WORDS  (POOL_WORDS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
